// ----- src/vs_pkg.sv -----
// vs_pkg: shared types, codes and constants of the ventilation sequencer.
// No dependencies; used by vs_step and ventilation_sequencer.
`default_nettype none

package vs_pkg;

  // Timer width default and configuration widths
  localparam int unsigned TimerBitsDefault = 16;
  localparam int unsigned DelayBits        = 16;
  localparam int unsigned CfgIndexBits     = 2;
  localparam int unsigned SecondsBits      = 16;

  // Configuration register indexes
  localparam logic [CfgIndexBits-1:0] CFG_VALVE_DELAY  = 2'd0;
  localparam logic [CfgIndexBits-1:0] CFG_HEATER_DELAY = 2'd1;

  // Reset values of the delay registers
  localparam logic [DelayBits-1:0] VALVE_DELAY_RST  = 16'd30;
  localparam logic [DelayBits-1:0] HEATER_DELAY_RST = 16'd60;

  // Fan speed codes
  localparam logic [1:0] FAN_OFF  = 2'd0;
  localparam logic [1:0] FAN_LOW  = 2'd1;
  localparam logic [1:0] FAN_HIGH = 2'd2;

  // Heater command codes
  localparam logic [1:0] HEATER_OFF = 2'd0;
  localparam logic [1:0] HEATER_ON  = 2'd1;

  // Event kinds
  typedef enum logic [1:0] {
    KIND_STEP   = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_FAN    = 2'd2,
    KIND_HEATER = 2'd3
  } kind_e;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    MODE_STARTING = 8'b0000_0001,
    MODE_RUNNING  = 8'b0000_0010,
    MODE_OPENING  = 8'b0000_0100,
    MODE_CLOSING  = 8'b0000_1000,
    MODE_HSTOP    = 8'b0001_0000,
    MODE_COOLING  = 8'b0010_0000,
    MODE_STOPPING = 8'b0100_0000,
    MODE_STOPPED  = 8'b1000_0000
  } mode_e;

  // Reported mode codes
  localparam logic [2:0] CODE_STARTING = 3'd0;
  localparam logic [2:0] CODE_RUNNING  = 3'd1;
  localparam logic [2:0] CODE_OPENING  = 3'd2;
  localparam logic [2:0] CODE_CLOSING  = 3'd3;
  localparam logic [2:0] CODE_HSTOP    = 3'd4;
  localparam logic [2:0] CODE_COOLING  = 3'd5;
  localparam logic [2:0] CODE_STOPPING = 3'd6;
  localparam logic [2:0] CODE_STOPPED  = 3'd7;

  // Relay levels
  typedef struct packed {
    logic fan;
    logic low;
    logic dir;
    logic motor;
    logic heat;
  } relays_t;

  // Sequencer state except the timer
  typedef struct packed {
    mode_e      mode;
    logic [1:0] fan_applied;
    logic       heater_applied;
    logic [1:0] fan_wanted;
    logic       heater_wanted;
    relays_t    relays;
  } seq_state_t;

  // Encode one-hot state into the reported mode code
  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    unique case (m)
      MODE_STARTING: code = CODE_STARTING;
      MODE_RUNNING:  code = CODE_RUNNING;
      MODE_OPENING:  code = CODE_OPENING;
      MODE_CLOSING:  code = CODE_CLOSING;
      MODE_HSTOP:    code = CODE_HSTOP;
      MODE_COOLING:  code = CODE_COOLING;
      MODE_STOPPING: code = CODE_STOPPING;
      default:       code = CODE_STOPPED;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- src/vs_step.sv -----
// vs_step: next-state logic of the sequencer for one event.
// Depends on vs_pkg.
`default_nettype none

module vs_step #(
  parameter int unsigned TIMER_BITS = vs_pkg::TimerBitsDefault
) (
  input  vs_pkg::seq_state_t          state_i,
  input  logic [TIMER_BITS-1:0]       count_i,
  input  logic [1:0]                  kind_i,
  input  logic [1:0]                  value_i,
  input  logic [vs_pkg::DelayBits-1:0] valve_delay_i,
  input  logic [vs_pkg::DelayBits-1:0] heater_delay_i,
  output vs_pkg::seq_state_t          state_o,
  output logic [TIMER_BITS-1:0]       count_o
);

  localparam logic [TIMER_BITS-1:0] TimerMax = {TIMER_BITS{1'b1}};

  // Delay loaded into the timer, saturated at the timer's maximum
  function automatic logic [TIMER_BITS-1:0] sat_load(logic [vs_pkg::DelayBits-1:0] d);
    logic [32:0] ext;
    logic [32:0] top;
    ext = 33'(d);
    top = 33'(TimerMax);
    return (ext > top) ? TimerMax : ext[TIMER_BITS-1:0];
  endfunction

  // Apply a fan speed; fan off is held back while the heater is on
  function automatic vs_pkg::seq_state_t drive_fan(vs_pkg::seq_state_t s, logic [1:0] speed);
    vs_pkg::seq_state_t r;
    r = s;
    r.fan_applied = speed;
    case (speed)
      vs_pkg::FAN_OFF: begin
        if (!s.heater_applied) begin
          r.relays.low = 1'b0;
          r.relays.fan = 1'b0;
        end
      end
      vs_pkg::FAN_LOW: begin
        r.relays.fan = 1'b1;
        r.relays.low = 1'b1;
      end
      vs_pkg::FAN_HIGH: begin
        r.relays.fan = 1'b1;
        r.relays.low = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  logic [TIMER_BITS-1:0] valve_load;
  logic [TIMER_BITS-1:0] heater_load;
  logic                  count_zero;
  logic                  fan_req;

  assign valve_load  = sat_load(valve_delay_i);
  assign heater_load = sat_load(heater_delay_i);
  assign count_zero  = (count_i == '0);
  assign fan_req     = (state_i.fan_wanted != vs_pkg::FAN_OFF);

  // Event handling
  always_comb begin
    vs_pkg::seq_state_t s;
    logic [TIMER_BITS-1:0] c;
    s = state_i;
    c = count_i;
    case (vs_pkg::kind_e'(kind_i))
      vs_pkg::KIND_STEP: begin
        unique case (state_i.mode)
          vs_pkg::MODE_STOPPED: begin
            if (fan_req) s.mode = vs_pkg::MODE_STARTING;
          end
          vs_pkg::MODE_STARTING: begin
            s.relays.dir   = 1'b1;
            s.relays.motor = 1'b1;
            c              = valve_load;
            s.mode         = vs_pkg::MODE_OPENING;
          end
          vs_pkg::MODE_OPENING: begin
            if (count_zero) begin
              s.relays.motor   = 1'b0;
              s.relays.dir     = 1'b0;
              s                = drive_fan(s, state_i.fan_wanted);
              s.heater_applied = state_i.heater_wanted;
              s.relays.heat    = state_i.heater_wanted;
              s.mode           = vs_pkg::MODE_RUNNING;
            end else if (!fan_req) begin
              s.mode = vs_pkg::MODE_CLOSING;
            end
          end
          vs_pkg::MODE_RUNNING: begin
            if (!fan_req) begin
              s.mode = vs_pkg::MODE_STOPPING;
            end else begin
              if (state_i.fan_applied != state_i.fan_wanted) begin
                s = drive_fan(s, state_i.fan_wanted);
              end
              if (state_i.heater_applied != state_i.heater_wanted) begin
                if (!state_i.heater_wanted) begin
                  s.mode = vs_pkg::MODE_HSTOP;
                end else begin
                  s.heater_applied = state_i.heater_wanted;
                  s.relays.heat    = state_i.heater_wanted;
                end
              end
            end
          end
          vs_pkg::MODE_STOPPING: begin
            if (state_i.heater_applied) begin
              s.mode = vs_pkg::MODE_HSTOP;
            end else begin
              s              = drive_fan(s, vs_pkg::FAN_OFF);
              s.relays.dir   = 1'b0;
              s.relays.motor = 1'b1;
              s.mode         = vs_pkg::MODE_CLOSING;
              c              = valve_load;
            end
          end
          vs_pkg::MODE_HSTOP: begin
            s.relays.heat = 1'b0;
            c             = heater_load;
            s.mode        = vs_pkg::MODE_COOLING;
          end
          vs_pkg::MODE_COOLING: begin
            if (count_zero) begin
              s.heater_applied = 1'b0;
              s.mode           = vs_pkg::MODE_RUNNING;
              c                = valve_load;
            end else begin
              if (state_i.fan_applied != state_i.fan_wanted) begin
                s = drive_fan(s, state_i.fan_wanted);
              end
              if (state_i.heater_wanted && fan_req) begin
                s.mode = vs_pkg::MODE_OPENING;
                c      = '0;
              end
            end
          end
          vs_pkg::MODE_CLOSING: begin
            if (count_zero) begin
              s.relays.motor = 1'b0;
              s.relays.dir   = 1'b0;
              s.mode         = vs_pkg::MODE_STOPPED;
            end else if (fan_req) begin
              s.mode = vs_pkg::MODE_STARTING;
            end
          end
          default: ;
        endcase
      end
      // Timer tick, saturating at zero
      vs_pkg::KIND_TICK: begin
        if (!count_zero) c = count_i - TIMER_BITS'(1);
      end
      // Fan command; speeds above high are dropped
      vs_pkg::KIND_FAN: begin
        if (value_i <= vs_pkg::FAN_HIGH) s.fan_wanted = value_i;
      end
      // Heater command; codes above on are dropped
      default: begin
        if (value_i <= vs_pkg::HEATER_ON) s.heater_wanted = value_i[0];
      end
    endcase
    state_o = s;
    count_o = c;
  end

endmodule

`default_nettype wire

// ----- src/ventilation_sequencer.sv -----
// ventilation_sequencer: top level of the fan / valve / heater sequencer.
// Depends on vs_pkg and vs_step.
//
//  channel | signals                                                | direction
//  --------+--------------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, kind_i, value_i                | input
//  out     | out_valid_o, out_ready_i, relay/mode/timer             | output
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i      | input
//
// One event per cycle unless stalled. Each transfer updates the state registers
// in the same cycle; those registers are the result shown on the next cycle.
// A new event is taken while the previous result is being taken, so the
// output side alone sets the pace. Reset puts the sequencer in stopped
// with all relays off and the delays at 30 s and 60 s. Config is always ready.
`default_nettype none

module ventilation_sequencer #(
  parameter int unsigned TIMER_BITS = vs_pkg::TimerBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // event input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      kind_i,
  input  logic [1:0]                      value_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            fan_drive_o,
  output logic                            fan_low_drive_o,
  output logic                            valve_direction_o,
  output logic                            valve_motor_o,
  output logic                            heater_drive_o,
  output logic [2:0]                      mode_o,
  output logic [vs_pkg::SecondsBits-1:0]  seconds_left_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vs_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [vs_pkg::DelayBits-1:0]    cfg_data_i
);

  vs_pkg::seq_state_t              state_q, state_d;
  logic [TIMER_BITS-1:0]           count_q, count_d;
  logic                            out_valid_q;
  logic [vs_pkg::DelayBits-1:0]    valve_delay_q;
  logic [vs_pkg::DelayBits-1:0]    heater_delay_q;
  logic                            in_xfer;
  logic [32:0]                     count_ext;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Next state for the event on the input
  vs_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .state_i        (state_q),
    .count_i        (count_q),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .valve_delay_i  (valve_delay_q),
    .heater_delay_i (heater_delay_q),
    .state_o        (state_d),
    .count_o        (count_d)
  );

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode           <= vs_pkg::MODE_STOPPED;
      state_q.fan_applied    <= vs_pkg::FAN_OFF;
      state_q.heater_applied <= 1'b0;
      state_q.fan_wanted     <= vs_pkg::FAN_OFF;
      state_q.heater_wanted  <= 1'b0;
      state_q.relays         <= '0;
      count_q                <= '0;
      out_valid_q            <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_q <= state_d;
        count_q <= count_d;
      end
      if (in_ready_o) out_valid_q <= in_valid_i;
    end
  end

  // Delay registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valve_delay_q  <= vs_pkg::VALVE_DELAY_RST;
      heater_delay_q <= vs_pkg::HEATER_DELAY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vs_pkg::CFG_VALVE_DELAY:  valve_delay_q  <= cfg_data_i;
        vs_pkg::CFG_HEATER_DELAY: heater_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Result fields
  assign count_ext         = 33'(count_q);
  assign out_valid_o       = out_valid_q;
  assign fan_drive_o       = state_q.relays.fan;
  assign fan_low_drive_o   = state_q.relays.low;
  assign valve_direction_o = state_q.relays.dir;
  assign valve_motor_o     = state_q.relays.motor;
  assign heater_drive_o    = state_q.relays.heat;
  assign mode_o            = vs_pkg::mode_code(state_q.mode);
  assign seconds_left_o    = count_ext[vs_pkg::SecondsBits-1:0];

endmodule

`default_nettype wire
